// ===== src/rnl_pkg.sv =====
`default_nettype none

package rnl_pkg;

  localparam int ROUTE_CAPACITY = 32;

  localparam int OPCODE_W = 4;
  localparam int ID_W     = 15;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 16;
  localparam int FOUND_W  = 5;
  localparam int LEN_W    = 6;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  // cells per first-level group of the scan tree
  localparam int GRP = 8;

  localparam logic [SLOT_W-1:0] SLOT_EMPTY = {SLOT_W{1'b1}};

  typedef enum logic [OPCODE_W-1:0] {
    OP_CLEAR     = 4'd0,
    OP_APPEND    = 4'd1,
    OP_INS_DEPOT = 4'd2,
    OP_INS_AT    = 4'd3,
    OP_REM_AT    = 4'd4,
    OP_REM_FIRST = 4'd5,
    OP_REM_LAST  = 4'd6,
    OP_QUERY     = 4'd7,
    OP_READ      = 4'd8,
    OP_WRITE     = 4'd9
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 3'd0,
    ST_FULL     = 3'd1,
    ST_BAD_POS  = 3'd2,
    ST_DUP      = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // per-cell update command
  typedef enum logic [2:0] {
    CK_HOLD   = 3'd0,
    CK_CLEAR  = 3'd1,
    CK_LOAD   = 3'd2,
    CK_INSERT = 3'd3,
    CK_REMOVE = 3'd4
  } cell_kind_t;

  typedef struct packed {
    logic hit;   // live entry equal to node id
    logic tail;  // last live entry equal to the depot
    logic pen;   // entry before last equal to node id
  } cell_flags_t;

  typedef struct packed {
    logic any;
    logic two;
    logic tail;
    logic pen;
  } scan_res_t;

endpackage

`default_nettype wire

// ===== src/rnl_cell.sv =====
`default_nettype none

module rnl_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 6
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire rnl_pkg::cell_kind_t          kind_i,
  input  wire logic [CNT_W-1:0]             at_i,
  input  wire logic [CNT_W-1:0]             lim_i,
  input  wire logic [CNT_W-1:0]             count_i,
  input  wire logic [rnl_pkg::ID_W-1:0]     id_i,
  input  wire logic [rnl_pkg::POS_W-1:0]    pos_i,
  input  wire logic [rnl_pkg::SLOT_W-1:0]   depot_i,
  input  wire logic [rnl_pkg::SLOT_W-1:0]   below_i,
  input  wire logic [rnl_pkg::SLOT_W-1:0]   above_i,
  output logic      [rnl_pkg::SLOT_W-1:0]   slot_o,
  output rnl_pkg::cell_flags_t              flags_o,
  output logic      [rnl_pkg::SLOT_W-1:0]   rd_o
);

  localparam int XW = ((CNT_W > rnl_pkg::POS_W) ? CNT_W : rnl_pkg::POS_W) + 1;
  localparam logic [CNT_W-1:0] ME    = CNT_W'(IDX);
  localparam logic [XW-1:0]    ME_X  = XW'(IDX);
  localparam logic [XW-1:0]    ME_X1 = XW'(IDX + 1);
  localparam logic [XW-1:0]    ME_X2 = XW'(IDX + 2);

  logic [rnl_pkg::SLOT_W-1:0] slot_r;
  logic [rnl_pkg::SLOT_W-1:0] slot_nxt;
  logic [rnl_pkg::SLOT_W-1:0] id_ext;

  assign id_ext = {1'b0, id_i};

  always_comb begin
    slot_nxt = slot_r;
    case (kind_i)
      rnl_pkg::CK_CLEAR: slot_nxt = rnl_pkg::SLOT_EMPTY;
      rnl_pkg::CK_LOAD: begin
        if (ME == at_i) slot_nxt = id_ext;
      end
      rnl_pkg::CK_INSERT: begin
        if (ME == at_i) slot_nxt = id_ext;
        else if (ME > at_i && ME < lim_i) slot_nxt = below_i;
      end
      rnl_pkg::CK_REMOVE: begin
        if (ME >= at_i && ME < lim_i) slot_nxt = above_i;
      end
      default: slot_nxt = slot_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= rnl_pkg::SLOT_EMPTY;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  assign slot_o       = slot_r;
  assign flags_o.hit  = (slot_r == id_ext) && (ME < count_i);
  assign flags_o.tail = (ME_X1 == XW'(count_i)) && (slot_r == depot_i);
  assign flags_o.pen  = (ME_X2 == XW'(count_i)) && (slot_r == id_ext);
  assign rd_o         = (XW'(pos_i) == ME_X) ? slot_r : '0;

endmodule

`default_nettype wire

// ===== src/rnl_scan.sv =====
`default_nettype none

module rnl_scan #(
  parameter int CAP = 32,
  parameter int FW  = 5
) (
  input  wire logic                        clk,
  input  wire rnl_pkg::cell_flags_t        flags_i [CAP],
  input  wire logic [rnl_pkg::SLOT_W-1:0]  rd_i [CAP],
  output rnl_pkg::scan_res_t               res_o,
  output logic      [FW-1:0]               first_o,
  output logic      [rnl_pkg::SLOT_W-1:0]  val_o
);

  localparam int GRP  = rnl_pkg::GRP;
  localparam int GW   = $clog2(GRP);
  localparam int NG   = (CAP + GRP - 1) / GRP;
  localparam int NPAD = NG * GRP;
  localparam int NG_W = FW - GW;

  rnl_pkg::cell_flags_t       fl_pad [NPAD];
  logic [rnl_pkg::SLOT_W-1:0] rd_pad [NPAD];

  for (genvar k = 0; k < NPAD; k++) begin : g_pad
    if (k < CAP) begin : g_live
      assign fl_pad[k] = flags_i[k];
      assign rd_pad[k] = rd_i[k];
    end else begin : g_zero
      assign fl_pad[k] = '0;
      assign rd_pad[k] = '0;
    end
  end

  // first level: one result per group of cells
  rnl_pkg::scan_res_t         grp_nxt   [NG];
  logic [GW-1:0]              gfirst_nxt [NG];
  logic [rnl_pkg::SLOT_W-1:0] gval_nxt  [NG];
  rnl_pkg::scan_res_t         grp_r     [NG];
  logic [GW-1:0]              gfirst_r  [NG];
  logic [rnl_pkg::SLOT_W-1:0] gval_r    [NG];

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_nxt[g]    = '0;
      gfirst_nxt[g] = '0;
      gval_nxt[g]   = '0;
      for (int j = 0; j < GRP; j++) begin
        grp_nxt[g].two  = grp_nxt[g].two | (grp_nxt[g].any & fl_pad[g*GRP+j].hit);
        grp_nxt[g].any  = grp_nxt[g].any | fl_pad[g*GRP+j].hit;
        grp_nxt[g].tail = grp_nxt[g].tail | fl_pad[g*GRP+j].tail;
        grp_nxt[g].pen  = grp_nxt[g].pen | fl_pad[g*GRP+j].pen;
        gval_nxt[g]     = gval_nxt[g] | rd_pad[g*GRP+j];
      end
      for (int j = GRP - 1; j >= 0; j--) begin
        if (fl_pad[g*GRP+j].hit) gfirst_nxt[g] = GW'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NG; g++) begin
      grp_r[g]    <= grp_nxt[g];
      gfirst_r[g] <= gfirst_nxt[g];
      gval_r[g]   <= gval_nxt[g];
    end
  end

  // second level: across groups
  rnl_pkg::scan_res_t         res_nxt;
  logic [FW-1:0]              first_nxt;
  logic [rnl_pkg::SLOT_W-1:0] val_nxt;

  always_comb begin
    res_nxt   = '0;
    first_nxt = '0;
    val_nxt   = '0;
    for (int g = 0; g < NG; g++) begin
      res_nxt.two  = res_nxt.two | grp_r[g].two | (res_nxt.any & grp_r[g].any);
      res_nxt.any  = res_nxt.any | grp_r[g].any;
      res_nxt.tail = res_nxt.tail | grp_r[g].tail;
      res_nxt.pen  = res_nxt.pen | grp_r[g].pen;
      val_nxt      = val_nxt | gval_r[g];
    end
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_r[g].any) first_nxt = {NG_W'(g), gfirst_r[g]};
    end
  end

  always_ff @(posedge clk) begin
    res_o   <= res_nxt;
    first_o <= first_nxt;
    val_o   <= val_nxt;
  end

endmodule

`default_nettype wire

// ===== src/route_node_list_engine.sv =====
// Channel  Dir  Bits  Contents (lowest bit first)
// in_      in   32    opcode[3:0], node_id[18:4], position[24:19]
// out_     out  40    status[2:0], slot_value[18:3], found_position[23:19],
//                     route_length[29:24], contains[30], starts_with[31], ends_with[32]
//
// One transaction at a time: steps PRE_A, PRE_B, EXEC, POST_A, POST_B and FIN lead from input
// acceptance to a registered result, set by the two-level scan tree run before and after the cell update.
// The next input is taken while a result still waits on out_tready.
// Synchronous active-low reset empties the route: all slots -1, length 0.
// A stalled result holds the engine in its last step until taken.
`default_nettype none

module route_node_list_engine #(
  parameter int ROUTE_CAPACITY = rnl_pkg::ROUTE_CAPACITY
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // opcode, node_id, position
  input  wire logic [rnl_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // status, slot_value, found_position, route_length, contains, starts_with, ends_with
  output logic      [rnl_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam int CAP   = ROUTE_CAPACITY;
  localparam int CNT_W = $clog2(CAP + 1);
  localparam int NG    = (CAP + rnl_pkg::GRP - 1) / rnl_pkg::GRP;
  localparam int NG_W  = (NG > 1) ? $clog2(NG) : 1;
  localparam int FW    = NG_W + $clog2(rnl_pkg::GRP);
  localparam int XW    = ((CNT_W > rnl_pkg::POS_W) ? CNT_W : rnl_pkg::POS_W) + 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAP);
  localparam logic [XW-1:0]    CAP_X    = XW'(CAP);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRE_A,
    S_PRE_B,
    S_EXEC,
    S_POST_A,
    S_POST_B,
    S_FIN
  } state_t;

  state_t                          state_r, state_nxt;
  rnl_pkg::op_t                    op_r, op_nxt;
  logic [rnl_pkg::ID_W-1:0]        id_r, id_nxt;
  logic [rnl_pkg::POS_W-1:0]       pos_r, pos_nxt;
  logic [CNT_W-1:0]                count_r, count_nxt;
  rnl_pkg::status_t                status_r, status_nxt;
  logic [rnl_pkg::SLOT_W-1:0]      value_r, value_nxt;
  logic [rnl_pkg::FOUND_W-1:0]     found_r, found_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [rnl_pkg::OUT_DATA_W-1:0]  out_data_r, out_data_nxt;

  rnl_pkg::cell_kind_t             kind_w;
  logic [CNT_W-1:0]                at_w;
  logic [CNT_W-1:0]                lim_w;

  logic [rnl_pkg::SLOT_W-1:0]      slot_w  [CAP];
  logic [rnl_pkg::SLOT_W-1:0]      below_w [CAP];
  logic [rnl_pkg::SLOT_W-1:0]      above_w [CAP];
  logic [rnl_pkg::SLOT_W-1:0]      rd_w    [CAP];
  rnl_pkg::cell_flags_t            flg_w   [CAP];

  rnl_pkg::scan_res_t              res_w;
  logic [FW-1:0]                   first_w;
  logic [rnl_pkg::SLOT_W-1:0]      val_w;

  logic                            starts_w;

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    if (i == 0) begin : g_bot
      assign below_w[i] = rnl_pkg::SLOT_EMPTY;
    end else begin : g_mid_b
      assign below_w[i] = slot_w[i-1];
    end
    if (i == CAP - 1) begin : g_top
      assign above_w[i] = rnl_pkg::SLOT_EMPTY;
    end else begin : g_mid_a
      assign above_w[i] = slot_w[i+1];
    end

    rnl_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .kind_i  (kind_w),
      .at_i    (at_w),
      .lim_i   (lim_w),
      .count_i (count_r),
      .id_i    (id_r),
      .pos_i   (pos_r),
      .depot_i (slot_w[0]),
      .below_i (below_w[i]),
      .above_i (above_w[i]),
      .slot_o  (slot_w[i]),
      .flags_o (flg_w[i]),
      .rd_o    (rd_w[i])
    );
  end

  rnl_scan #(
    .CAP (CAP),
    .FW  (FW)
  ) u_scan (
    .clk     (clk),
    .flags_i (flg_w),
    .rd_i    (rd_w),
    .res_o   (res_w),
    .first_o (first_w),
    .val_o   (val_w)
  );

  assign starts_w = (count_r >= CNT_W'(2)) && (slot_w[1] == {1'b0, id_r});

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    pos_nxt       = pos_r;
    count_nxt     = count_r;
    status_nxt    = status_r;
    value_nxt     = value_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    kind_w        = rnl_pkg::CK_HOLD;
    at_w          = '0;
    lim_w         = '0;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = rnl_pkg::op_t'(in_tdata[3:0]);
          id_nxt    = in_tdata[18:4];
          pos_nxt   = in_tdata[24:19];
          state_nxt = S_PRE_A;
        end
      end
      S_PRE_A: state_nxt = S_PRE_B;
      S_PRE_B: state_nxt = S_EXEC;
      S_EXEC: begin
        status_nxt = rnl_pkg::ST_DONE;
        value_nxt  = '0;
        found_nxt  = '0;
        state_nxt  = S_POST_A;
        unique case (op_r)
          rnl_pkg::OP_CLEAR: begin
            kind_w    = rnl_pkg::CK_CLEAR;
            count_nxt = '0;
          end
          rnl_pkg::OP_APPEND: begin
            if (res_w.two) begin
              status_nxt = rnl_pkg::ST_DUP;
            end else if (count_r == CNT_FULL) begin
              status_nxt = rnl_pkg::ST_FULL;
            end else begin
              // trailing depot: new id goes before it, depot shifts up
              kind_w    = rnl_pkg::CK_INSERT;
              at_w      = (count_r >= CNT_W'(3) && res_w.tail) ? count_r - 1'b1 : count_r;
              lim_w     = count_r + 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end
          rnl_pkg::OP_INS_DEPOT: begin
            if (count_r == CNT_FULL) begin
              status_nxt = rnl_pkg::ST_FULL;
            end else begin
              kind_w    = rnl_pkg::CK_INSERT;
              at_w      = CNT_W'(1);
              lim_w     = count_r + 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end
          rnl_pkg::OP_INS_AT: begin
            if (count_r == CNT_FULL) begin
              status_nxt = rnl_pkg::ST_FULL;
            end else if (XW'(pos_r) > XW'(count_r)) begin
              status_nxt = rnl_pkg::ST_BAD_POS;
            end else begin
              kind_w    = rnl_pkg::CK_INSERT;
              at_w      = CNT_W'(pos_r);
              lim_w     = count_r + 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end
          rnl_pkg::OP_REM_AT: begin
            if (XW'(pos_r) >= XW'(count_r)) begin
              status_nxt = rnl_pkg::ST_BAD_POS;
            end else begin
              kind_w    = rnl_pkg::CK_REMOVE;
              at_w      = CNT_W'(pos_r);
              lim_w     = count_r;
              count_nxt = count_r - 1'b1;
            end
          end
          rnl_pkg::OP_REM_FIRST: begin
            if (count_r == '0) begin
              status_nxt = rnl_pkg::ST_BAD_POS;
            end else begin
              kind_w    = rnl_pkg::CK_REMOVE;
              at_w      = '0;
              lim_w     = count_r - 1'b1;
              count_nxt = count_r - 1'b1;
            end
          end
          rnl_pkg::OP_REM_LAST: begin
            if (count_r == '0) status_nxt = rnl_pkg::ST_BAD_POS;
            else count_nxt = count_r - 1'b1;
          end
          rnl_pkg::OP_QUERY: begin
            if (res_w.any) found_nxt = rnl_pkg::FOUND_W'(first_w);
            else status_nxt = rnl_pkg::ST_NOTFOUND;
          end
          rnl_pkg::OP_READ: begin
            if (XW'(pos_r) >= CAP_X) status_nxt = rnl_pkg::ST_BAD_POS;
            else value_nxt = val_w;
          end
          rnl_pkg::OP_WRITE: begin
            if (XW'(pos_r) >= CAP_X) begin
              status_nxt = rnl_pkg::ST_BAD_POS;
            end else begin
              kind_w = rnl_pkg::CK_LOAD;
              at_w   = CNT_W'(pos_r);
            end
          end
          default: status_nxt = rnl_pkg::ST_DONE;
        endcase
      end
      S_POST_A: state_nxt = S_POST_B;
      S_POST_B: state_nxt = S_FIN;
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {7'b0, res_w.pen, starts_w, res_w.any,
                           rnl_pkg::LEN_W'(count_r), found_r, value_r, status_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    pos_r      <= pos_nxt;
    status_r   <= status_nxt;
    value_r    <= value_nxt;
    found_r    <= found_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== src/rnl_checker.sv =====
`default_nettype none

module rnl_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [rnl_pkg::OUT_DATA_W-1:0]  out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transaction taken while one is in flight");

  a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[18] |-> out_tdata[18:3] == rnl_pkg::SLOT_EMPTY)
    else $error("negative slot value other than the empty marker");

  a_flags_contained: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[31] || out_tdata[32]) |-> out_tdata[30])
    else $error("start or end flag without contains flag");

  a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[23:19] != '0 |-> out_tdata[2:0] == rnl_pkg::ST_DONE)
    else $error("found position on a failed transaction");

endmodule

bind route_node_list_engine rnl_checker u_rnl_checker (.*);

`default_nettype wire

// ===== dv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rnl_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 4'd10;
  localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 4'd15;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRESSURE_HOLD  = 200;
  localparam int DRAIN_CYCLES   = 16;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_value;
    logic [FOUND_W-1:0]  found_position;
    logic [LEN_W-1:0]    route_length;
    logic                contains_node;
    logic                starts_with_node;
    logic                ends_with_node;
  } route_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // opcode, node_id, position
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // status, slot_value, found_position, route_length, contains, starts_with, ends_with
  logic [OUT_DATA_W-1:0] out_tdata;

  // predicted route contents
  logic [SLOT_W-1:0] route_mem [ROUTE_CAPACITY];
  int unsigned route_len;

  route_result_t pending_route_results [$];
  int mismatch_count = 0;
  int idle_cycles = 0;

  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  bit rx_hold_req = 1'b0;
  int rx_wait = 0;

  route_node_list_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int unsigned route_hits(logic [SLOT_W-1:0] v);
    int unsigned n;
    n = 0;
    for (int i = 0; i < route_len; i++) begin
      if (route_mem[i] == v) n++;
    end
    return n;
  endfunction

  task automatic route_reset();
    for (int i = 0; i < ROUTE_CAPACITY; i++) route_mem[i] = SLOT_EMPTY;
    route_len = 0;
  endtask

  task automatic route_apply(input logic [OPCODE_W-1:0] op, input logic [ID_W-1:0] id,
                             input logic [POS_W-1:0] pos, output route_result_t r);
    logic [SLOT_W-1:0] id16;
    logic [SLOT_W-1:0] depot;
    int i;
    id16 = {1'b0, id};
    r = '0;
    case (op)
      OP_CLEAR: begin
        route_reset();
      end
      OP_APPEND: begin
        if (route_hits(id16) >= 2) begin
          r.status = ST_DUP;
        end else if (route_len >= ROUTE_CAPACITY) begin
          r.status = ST_FULL;
        end else if (route_len >= 3 && route_mem[route_len-1] == route_mem[0]) begin
          depot = route_mem[0];
          route_mem[route_len-1] = id16;
          route_mem[route_len] = depot;
          route_len++;
        end else begin
          route_mem[route_len] = id16;
          route_len++;
        end
      end
      OP_INS_DEPOT: begin
        if (route_len >= ROUTE_CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (i = route_len; i > 1; i--) route_mem[i] = route_mem[i-1];
          route_mem[1] = id16;
          route_len++;
        end
      end
      OP_INS_AT: begin
        if (route_len >= ROUTE_CAPACITY) begin
          r.status = ST_FULL;
        end else if (pos > route_len) begin
          r.status = ST_BAD_POS;
        end else begin
          for (i = route_len; i > pos; i--) route_mem[i] = route_mem[i-1];
          route_mem[pos] = id16;
          route_len++;
        end
      end
      OP_REM_AT: begin
        if (pos >= route_len) begin
          r.status = ST_BAD_POS;
        end else begin
          for (i = pos; i + 1 < route_len; i++) route_mem[i] = route_mem[i+1];
          route_mem[route_len-1] = (route_len < ROUTE_CAPACITY) ? route_mem[route_len]
                                                                 : SLOT_EMPTY;
          route_len--;
        end
      end
      OP_REM_FIRST: begin
        if (route_len == 0) begin
          r.status = ST_BAD_POS;
        end else begin
          for (i = 1; i < route_len; i++) route_mem[i-1] = route_mem[i];
          route_len--;
        end
      end
      OP_REM_LAST: begin
        if (route_len == 0) r.status = ST_BAD_POS;
        else route_len--;
      end
      OP_QUERY: begin
        r.status = ST_NOTFOUND;
        for (i = 0; i < route_len; i++) begin
          if (route_mem[i] == id16) begin
            r.found_position = i[FOUND_W-1:0];
            r.status = ST_DONE;
            break;
          end
        end
      end
      OP_READ: begin
        if (pos >= ROUTE_CAPACITY) r.status = ST_BAD_POS;
        else r.slot_value = route_mem[pos];
      end
      OP_WRITE: begin
        if (pos >= ROUTE_CAPACITY) r.status = ST_BAD_POS;
        else route_mem[pos] = id16;
      end
      default: ;
    endcase
    r.route_length = route_len[LEN_W-1:0];
    r.contains_node = route_hits(id16) != 0;
    r.starts_with_node = route_len >= 2 && route_mem[1] == id16;
    r.ends_with_node = route_len >= 2 && route_mem[route_len-2] == id16;
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_op(input logic [OPCODE_W-1:0] op, input logic [ID_W-1:0] id,
                         input logic [POS_W-1:0] pos);
    int gap;
    route_result_t r;
    gap = tx_steady ? 0 : gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_DATA_W-OPCODE_W-ID_W-POS_W){1'b0}}, pos, id, op};
    do @(posedge clk); while (!in_tready);
    route_apply(op, id, pos, r);
    pending_route_results.push_back(r);
  endtask

  function automatic logic [ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return ID_W'($urandom_range(0, 5));
    if (r < 75 && route_len > 0) return route_mem[$urandom_range(0, route_len-1)][ID_W-1:0];
    return ID_W'($urandom_range(0, 32767));
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return POS_W'($urandom_range(0, route_len + 1));
    if (r < 90) return POS_W'($urandom_range(0, 31));
    return POS_W'($urandom_range(32, 63));
  endfunction

  task automatic check_field(input string name, input logic [SLOT_W-1:0] exp_v,
                             input logic [SLOT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // receiver: random stalls, plus a long hold when requested
  initial begin
    forever begin
      @(posedge clk);
      if (rx_wait > 0) begin
        out_tready <= 1'b0;
        rx_wait--;
      end else if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_wait = PRESSURE_HOLD - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!rx_steady && $urandom_range(0, 99) < 20)
          rx_wait = ($urandom_range(0, 99) < 88) ? $urandom_range(1, 3) : $urandom_range(10, 50);
      end
    end
  end

  // result checking and watchdog
  always @(posedge clk) begin
    route_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_route_results.size() == 0) begin
        $error("result transaction with nothing expected: %0h", out_tdata);
        mismatch_count++;
      end else begin
        e = pending_route_results.pop_front();
        check_field("status", SLOT_W'(e.status), SLOT_W'(out_tdata[2:0]));
        check_field("slot_value", e.slot_value, out_tdata[18:3]);
        check_field("found_position", SLOT_W'(e.found_position), SLOT_W'(out_tdata[23:19]));
        check_field("route_length", SLOT_W'(e.route_length), SLOT_W'(out_tdata[29:24]));
        check_field("contains_node", SLOT_W'(e.contains_node), SLOT_W'(out_tdata[30]));
        check_field("starts_with_node", SLOT_W'(e.starts_with_node), SLOT_W'(out_tdata[31]));
        check_field("ends_with_node", SLOT_W'(e.ends_with_node), SLOT_W'(out_tdata[32]));
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic test_directed();
    send_op(OP_READ, '0, 6'd0);
    send_op(OP_REM_FIRST, '0, '0);
    send_op(OP_REM_LAST, '0, '0);
    send_op(OP_REM_AT, '0, 6'd0);
    send_op(OP_QUERY, 15'h7FFF, '0);
    send_op(OP_INS_DEPOT, 15'd5, '0);
    send_op(OP_CLEAR, '0, '0);
    send_op(OP_APPEND, 15'd0, '0);
    send_op(OP_APPEND, 15'h7FFF, '0);
    send_op(OP_APPEND, 15'd0, '0);
    // trailing depot stays last
    send_op(OP_APPEND, 15'd12, '0);
    send_op(OP_APPEND, 15'd0, '0);
    send_op(OP_INS_AT, 15'd7, 6'd5);
    send_op(OP_INS_AT, 15'h5555, 6'd4);
    send_op(OP_INS_AT, 15'h2AAA, 6'd1);
    send_op(OP_QUERY, 15'd12, '0);
    send_op(OP_REM_AT, 15'd12, 6'd2);
    send_op(OP_WRITE, 15'h7FFF, 6'd31);
    send_op(OP_WRITE, 15'd3, 6'd32);
    send_op(OP_READ, '0, 6'd63);
    send_op(OP_READ, 15'h7FFF, 6'd31);
    send_op(OP_SPARE_HI, 15'h7FFF, 6'd63);
    send_op(OP_SPARE_LO, 15'd0, 6'd0);
    send_op(OP_REM_FIRST, 15'h2AAA, '0);
    send_op(OP_REM_LAST, 15'd0, '0);
  endtask

  task automatic test_capacity();
    int r;
    for (int round = 0; round < 3; round++) begin
      send_op(OP_CLEAR, pick_id(), '0);
      while (route_len < ROUTE_CAPACITY) begin
        r = $urandom_range(0, 2);
        if (r == 0) send_op(OP_APPEND, ID_W'($urandom), '0);
        else if (r == 1) send_op(OP_INS_DEPOT, ID_W'($urandom), '0);
        else send_op(OP_INS_AT, ID_W'($urandom), POS_W'($urandom_range(0, route_len)));
      end
      send_op(OP_APPEND, ID_W'($urandom), '0);
      send_op(OP_INS_DEPOT, ID_W'($urandom), '0);
      send_op(OP_INS_AT, ID_W'($urandom), POS_W'($urandom_range(0, 63)));
      send_op(OP_REM_AT, pick_id(), POS_W'($urandom_range(0, ROUTE_CAPACITY-1)));
      send_op(OP_READ, pick_id(), POS_W'(ROUTE_CAPACITY-1));
      send_op(OP_APPEND, route_mem[0][ID_W-1:0], '0);
      send_op(OP_REM_AT, pick_id(), POS_W'(ROUTE_CAPACITY-1));
      send_op(OP_READ, pick_id(), POS_W'(ROUTE_CAPACITY-1));
      send_op(OP_QUERY, pick_id(), '0);
    end
  endtask

  task automatic test_backpressure();
    tx_steady = 1'b1;
    rx_hold_req = 1'b1;
    for (int i = 0; i < 24; i++) send_op(OP_APPEND, pick_id(), pick_pos());
    tx_steady = 1'b0;
  endtask

  task automatic test_random(input int n_items);
    int r;
    logic [OPCODE_W-1:0] op;
    logic [ID_W-1:0] id;
    for (int i = 0; i < n_items; i++) begin
      if (i % 100 == 0) begin
        tx_steady = $urandom_range(0, 99) < 20;
        rx_steady = $urandom_range(0, 99) < 20;
      end
      r = $urandom_range(0, 99);
      id = pick_id();
      if (r < 28) op = OP_APPEND;
      else if (r < 36) op = OP_INS_DEPOT;
      else if (r < 44) op = OP_INS_AT;
      else if (r < 54) op = OP_REM_AT;
      else if (r < 58) op = OP_REM_FIRST;
      else if (r < 63) op = OP_REM_LAST;
      else if (r < 73) op = OP_QUERY;
      else if (r < 83) op = OP_READ;
      else if (r < 90) op = OP_WRITE;
      else if (r < 92) op = OP_CLEAR;
      else if (r < 95) op = OPCODE_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      else begin
        // close the route with its depot
        op = OP_APPEND;
        id = route_mem[0][ID_W-1:0];
      end
      send_op(op, id, pick_pos());
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    route_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_capacity();
    test_backpressure();
    test_random(1300);
    in_tvalid <= 1'b0;
    while (pending_route_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_route_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
